FILE: rtl/tftt_pkg.sv
// Shared types, codes and defaults of the TCP flow table tracker.
`default_nettype none
package tftt_pkg;

   localparam int NUM_SETS_DEF  = 256;
   localparam int NUM_WAYS_DEF  = 4;
   localparam int TIME_BITS_DEF = 48;

   localparam logic [7:0] PROTO_TCP  = 8'd6;
   localparam logic       AF_INET    = 1'b1;
   localparam int         PORT_SHIFT = 16;

   localparam int INDEX_W = 10;
   localparam int START_W = 48;
   localparam int KEY_W   = 96;

   typedef enum logic [2:0] {
      ST_HIT         = 3'd0,
      ST_NEW         = 3'd1,
      ST_IGNORED     = 3'd2,
      ST_UNSUPPORTED = 3'd3,
      ST_FULL        = 3'd4
   } status_type;

   typedef enum logic [1:0] {
      S_CLEAR,
      S_IDLE,
      S_QUOT,
      S_LOOK
   } state_type;

   typedef struct packed {
      logic [31:0] ia;
      logic [31:0] oa;
      logic [15:0] ip;
      logic [15:0] op;
   } flow_key_type;

   typedef struct packed {
      logic full;
      logic empty;
   } fifo_stat_type;

endpackage
`default_nettype wire

FILE: rtl/tftt_ram.sv
// Generic single-write, single-read RAM with registered read data.
`default_nettype none
module tftt_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 2
) (
   input  wire logic                     clock,
   input  wire logic                     we,
   input  wire logic [$clog2(DEPTH)-1:0] waddr,
   input  wire logic [WIDTH-1:0]         wdata,
   input  wire logic                     re,
   input  wire logic [$clog2(DEPTH)-1:0] raddr,
   output logic      [WIDTH-1:0]         rdata
);

   logic [WIDTH-1:0] mem [DEPTH];

   always_ff @(posedge clock) begin
      if (we) begin
         mem[waddr] <= wdata;
      end
      if (re) begin
         rdata <= mem[raddr];
      end
   end

endmodule
`default_nettype wire

FILE: rtl/tftt_fifo.sv
// Two-entry queue between the classifier front and the table back end.
`default_nettype none
module tftt_fifo #(
   parameter int WIDTH = 8
) (
   input  wire logic                   clock,
   input  wire logic                   reset,
   input  wire logic                   push,
   input  wire logic [WIDTH-1:0]       push_data,
   input  wire logic                   pop,
   output logic      [WIDTH-1:0]       head,
   output tftt_pkg::fifo_stat_type     stat
);

   logic [WIDTH-1:0] slot_ff [2];
   logic [1:0]       count_ff, count_in;
   logic             wr_ff, wr_in, rd_ff, rd_in;

   always_comb begin
      count_in = count_ff + 2'(push) - 2'(pop);
      wr_in    = wr_ff ^ push;
      rd_in    = rd_ff ^ pop;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff <= '0;
         wr_ff    <= 1'b0;
         rd_ff    <= 1'b0;
      end else begin
         count_ff <= count_in;
         wr_ff    <= wr_in;
         rd_ff    <= rd_in;
      end
      if (push) begin
         slot_ff[wr_ff] <= push_data;
      end
   end

   assign head       = slot_ff[rd_ff];
   assign stat.full  = count_ff == 2'd2;
   assign stat.empty = count_ff == 2'd0;

endmodule
`default_nettype wire

FILE: rtl/tftt_front.sv
// Front end: accept a header, orient the key, classify and hash it.
`default_nettype none
module tftt_front #(
   parameter int TIME_BITS = tftt_pkg::TIME_BITS_DEF,
   localparam int ITEM_W = 2 + tftt_pkg::KEY_W + 32 + TIME_BITS
) (
   input  wire logic                 start,
   output logic                      busy,
   input  wire logic                 req_direction,
   input  wire logic                 req_is_ipv4,
   input  wire logic [7:0]           req_protocol,
   input  wire logic [31:0]          req_src_addr,
   input  wire logic [31:0]          req_dst_addr,
   input  wire logic [15:0]          req_src_port,
   input  wire logic [15:0]          req_dst_port,
   input  wire logic                 req_syn_bit,
   input  wire logic                 req_ack_bit,
   input  wire logic [47:0]          req_timestamp,
   input  wire logic                 clearing,
   input  tftt_pkg::fifo_stat_type   stat,
   output logic                      push,
   output logic [ITEM_W-1:0]         item
);

   tftt_pkg::flow_key_type key;
   logic                   unsup;
   logic [31:0]            hash;
   logic [TIME_BITS-1:0]   ts;

   always_comb begin
      key.ia = req_direction ? req_dst_addr : req_src_addr;
      key.oa = req_direction ? req_src_addr : req_dst_addr;
      key.ip = req_direction ? req_dst_port : req_src_port;
      key.op = req_direction ? req_src_port : req_dst_port;
      unsup  = (req_is_ipv4 != tftt_pkg::AF_INET) || (req_protocol != tftt_pkg::PROTO_TCP);
      hash   = ((32'(key.op) << tftt_pkg::PORT_SHIFT) + 32'(key.ip)) ^ key.ia ^ key.oa;
      ts     = TIME_BITS'(req_timestamp);
   end

   assign busy = stat.full || clearing;
   assign push = start && !busy;
   assign item = {unsup, req_syn_bit & req_ack_bit, key, hash, ts};

endmodule
`default_nettype wire

FILE: rtl/tftt_back.sv
// Back end: reduce the hash to a set, search the set and write it back.
`default_nettype none
module tftt_back #(
   parameter int NUM_SETS  = tftt_pkg::NUM_SETS_DEF,
   parameter int NUM_WAYS  = tftt_pkg::NUM_WAYS_DEF,
   parameter int TIME_BITS = tftt_pkg::TIME_BITS_DEF,
   localparam int ITEM_W = 2 + tftt_pkg::KEY_W + 32 + TIME_BITS
) (
   input  wire logic                 clock,
   input  wire logic                 reset,
   input  wire logic [ITEM_W-1:0]    head,
   input  tftt_pkg::fifo_stat_type   stat,
   output logic                      pop,
   output logic                      clearing,
   output logic                      rsp_valid,
   output logic [2:0]                rsp_status,
   output logic [9:0]                rsp_flow_index,
   output logic [47:0]               rsp_flow_start_time
);

   localparam int SW = $clog2(NUM_SETS);
   localparam int WW = (NUM_WAYS > 1) ? $clog2(NUM_WAYS) : 1;
   localparam int T  = TIME_BITS;
   localparam int EW = 1 + 64 + 32 + 2 * T;
   localparam int RW = NUM_WAYS * EW;
   localparam logic [63:0] RECIP = ((64'd1 << (32 + SW)) + 64'(NUM_SETS) - 64'd1)
                                   / 64'(NUM_SETS);
   localparam bit POW2 = (NUM_SETS & (NUM_SETS - 1)) == 0;

   tftt_pkg::state_type    state_ff, state_in;
   logic [ITEM_W-1:0]      item_ff, item_in;
   logic [SW-1:0]          set_ff, set_in, clr_ff, clr_in;
   logic [31:0]            q_ff, q_in;
   logic                   rsp_valid_ff, rsp_valid_in;
   tftt_pkg::status_type   status_ff, status_in;
   logic [9:0]             idx_ff, idx_in;
   logic [47:0]            start_ff, start_in;

   logic                   ram_we, ram_re;
   logic [SW-1:0]          ram_waddr, ram_raddr;
   logic [RW-1:0]          ram_wdata, ram_rdata;

   logic                   head_unsup, it_synack;
   logic [31:0]            head_hash, it_hash;
   tftt_pkg::flow_key_type it_key;
   logic [T-1:0]           it_ts;
   logic [64:0]            prod;
   logic [31:0]            set_calc;

   logic                   hit_any, free_any;
   logic [WW-1:0]          hit_way, free_way;
   logic [T-1:0]           hit_first;
   logic [31:0]            idx_full;
   logic [63:0]            first_wide;

   assign head_unsup = head[ITEM_W-1];
   assign head_hash  = head[T +: 32];
   assign it_synack  = item_ff[ITEM_W-2];
   assign it_key     = item_ff[T + 32 +: tftt_pkg::KEY_W];
   assign it_hash    = item_ff[T +: 32];
   assign it_ts      = item_ff[T-1:0];

   assign prod     = 65'(head_hash) * 65'(RECIP);
   assign set_calc = it_hash - 32'(q_ff * 32'(NUM_SETS));

   // Search all ways of the row just read.
   always_comb begin
      hit_any   = 1'b0;
      free_any  = 1'b0;
      hit_way   = '0;
      free_way  = '0;
      hit_first = '0;
      for (int w = NUM_WAYS - 1; w >= 0; w--) begin
         if (ram_rdata[w*EW + EW - 1]) begin
            if (ram_rdata[w*EW + 2*T +: 96] == {it_key.ia, it_key.oa, it_key.ip, it_key.op}) begin
               hit_any   = 1'b1;
               hit_way   = WW'(w);
               hit_first = ram_rdata[w*EW + T +: T];
            end
         end else begin
            free_any = 1'b1;
            free_way = WW'(w);
         end
      end
   end

   tftt_ram #(.WIDTH(RW), .DEPTH(NUM_SETS)) u_ram (
      .clock (clock),
      .we    (ram_we),
      .waddr (ram_waddr),
      .wdata (ram_wdata),
      .re    (ram_re),
      .raddr (ram_raddr),
      .rdata (ram_rdata)
   );

   always_comb begin
      state_in     = state_ff;
      item_in      = item_ff;
      set_in       = set_ff;
      clr_in       = clr_ff;
      q_in         = q_ff;
      pop          = 1'b0;
      ram_we       = 1'b0;
      ram_re       = 1'b0;
      ram_waddr    = set_ff;
      ram_raddr    = set_ff;
      ram_wdata    = ram_rdata;
      rsp_valid_in = 1'b0;
      status_in    = tftt_pkg::ST_HIT;
      idx_in       = '0;
      start_in     = '0;
      idx_full     = '0;
      first_wide   = '0;
      unique case (state_ff)
         tftt_pkg::S_CLEAR: begin
            ram_we    = 1'b1;
            ram_waddr = clr_ff;
            ram_wdata = '0;
            clr_in    = clr_ff + 1'b1;
            if (clr_ff == SW'(NUM_SETS - 1)) begin
               state_in = tftt_pkg::S_IDLE;
            end
         end
         tftt_pkg::S_IDLE: begin
            if (!stat.empty) begin
               pop     = 1'b1;
               item_in = head;
               if (head_unsup) begin
                  rsp_valid_in = 1'b1;
                  status_in    = tftt_pkg::ST_UNSUPPORTED;
               end else if (POW2) begin
                  ram_re    = 1'b1;
                  ram_raddr = head_hash[SW-1:0];
                  set_in    = head_hash[SW-1:0];
                  state_in  = tftt_pkg::S_LOOK;
               end else begin
                  q_in     = 32'(prod >> (32 + SW));
                  state_in = tftt_pkg::S_QUOT;
               end
            end
         end
         tftt_pkg::S_QUOT: begin
            ram_re    = 1'b1;
            ram_raddr = set_calc[SW-1:0];
            set_in    = set_calc[SW-1:0];
            state_in  = tftt_pkg::S_LOOK;
         end
         tftt_pkg::S_LOOK: begin
            rsp_valid_in = 1'b1;
            state_in     = tftt_pkg::S_IDLE;
            priority if (hit_any) begin
               // Refresh last-seen time only.
               idx_full   = 32'(set_ff) * 32'(NUM_WAYS) + 32'(hit_way);
               first_wide = 64'(hit_first);
               status_in  = tftt_pkg::ST_HIT;
               idx_in     = idx_full[tftt_pkg::INDEX_W-1:0];
               start_in   = first_wide[tftt_pkg::START_W-1:0];
               ram_we     = 1'b1;
               ram_wdata[hit_way*EW +: T] = it_ts;
            end else if (!it_synack) begin
               status_in = tftt_pkg::ST_IGNORED;
            end else if (!free_any) begin
               status_in = tftt_pkg::ST_FULL;
            end else begin
               idx_full   = 32'(set_ff) * 32'(NUM_WAYS) + 32'(free_way);
               first_wide = 64'(it_ts);
               status_in  = tftt_pkg::ST_NEW;
               idx_in     = idx_full[tftt_pkg::INDEX_W-1:0];
               start_in   = first_wide[tftt_pkg::START_W-1:0];
               ram_we     = 1'b1;
               ram_wdata[free_way*EW +: EW] = {1'b1, it_key.ia, it_key.oa, it_key.ip,
                                               it_key.op, it_ts, it_ts};
            end
         end
         default: begin
            state_in = tftt_pkg::S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= tftt_pkg::S_CLEAR;
         clr_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         clr_ff       <= clr_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      item_ff   <= item_in;
      set_ff    <= set_in;
      q_ff      <= q_in;
      status_ff <= status_in;
      idx_ff    <= idx_in;
      start_ff  <= start_in;
   end

   assign clearing            = state_ff == tftt_pkg::S_CLEAR;
   assign rsp_valid           = rsp_valid_ff;
   assign rsp_status          = status_ff;
   assign rsp_flow_index      = idx_ff;
   assign rsp_flow_start_time = start_ff;

`ifndef SYNTHESIS
   a_look_emits: assert property (@(posedge clock) disable iff (reset)
      state_ff == tftt_pkg::S_LOOK |=> rsp_valid_ff)
      else $error("lookup ended without a result");
   a_no_rsp_clear: assert property (@(posedge clock) disable iff (reset)
      clearing |-> !rsp_valid_ff && !pop)
      else $error("item handled during clearing pass");
   a_new_from_look: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && status_ff == tftt_pkg::ST_NEW |-> $past(state_ff) == tftt_pkg::S_LOOK)
      else $error("new flow reported outside lookup");
   a_quot_to_look: assert property (@(posedge clock) disable iff (reset)
      state_ff == tftt_pkg::S_QUOT |=> state_ff == tftt_pkg::S_LOOK)
      else $error("set reduction did not lead to lookup");
`endif

endmodule
`default_nettype wire

FILE: rtl/tcp_flow_table_tracker_unit.sv
// Top level of the TCP flow table tracker.
// One result per accepted header, on the rsp_ ports for one cycle under rsp_valid;
// the receiver cannot stall. Headers enter a two-entry queue when start is high and
// busy low. The back end handles one header at a time: a non-IPv4/TCP header is
// answered from the idle state, any other goes through a set read, then compare and
// write-back of the set row, preceded when NUM_SETS is not a power of two by a
// reciprocal reduction of the hash. After reset busy stays high while the table is
// cleared one set per cycle.
`default_nettype none
module tcp_flow_table_tracker_unit #(
   parameter int NUM_SETS  = tftt_pkg::NUM_SETS_DEF,
   parameter int NUM_WAYS  = tftt_pkg::NUM_WAYS_DEF,
   parameter int TIME_BITS = tftt_pkg::TIME_BITS_DEF
) (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        start,
   output logic             busy,
   input  wire logic        req_direction,
   input  wire logic        req_is_ipv4,
   input  wire logic [7:0]  req_protocol,
   input  wire logic [31:0] req_src_addr,
   input  wire logic [31:0] req_dst_addr,
   input  wire logic [15:0] req_src_port,
   input  wire logic [15:0] req_dst_port,
   input  wire logic        req_syn_bit,
   input  wire logic        req_ack_bit,
   input  wire logic [47:0] req_timestamp,
   output logic             rsp_valid,
   output logic [2:0]       rsp_status,
   output logic [9:0]       rsp_flow_index,
   output logic [47:0]      rsp_flow_start_time
);

   localparam int ITEM_W = 2 + tftt_pkg::KEY_W + 32 + TIME_BITS;

   logic                    push, pop, clearing;
   logic [ITEM_W-1:0]       item, head;
   tftt_pkg::fifo_stat_type stat;

   tftt_front #(.TIME_BITS(TIME_BITS)) u_front (
      .start         (start),
      .busy          (busy),
      .req_direction (req_direction),
      .req_is_ipv4   (req_is_ipv4),
      .req_protocol  (req_protocol),
      .req_src_addr  (req_src_addr),
      .req_dst_addr  (req_dst_addr),
      .req_src_port  (req_src_port),
      .req_dst_port  (req_dst_port),
      .req_syn_bit   (req_syn_bit),
      .req_ack_bit   (req_ack_bit),
      .req_timestamp (req_timestamp),
      .clearing      (clearing),
      .stat          (stat),
      .push          (push),
      .item          (item)
   );

   tftt_fifo #(.WIDTH(ITEM_W)) u_fifo (
      .clock     (clock),
      .reset     (reset),
      .push      (push),
      .push_data (item),
      .pop       (pop),
      .head      (head),
      .stat      (stat)
   );

   tftt_back #(
      .NUM_SETS  (NUM_SETS),
      .NUM_WAYS  (NUM_WAYS),
      .TIME_BITS (TIME_BITS)
   ) u_back (
      .clock               (clock),
      .reset               (reset),
      .head                (head),
      .stat                (stat),
      .pop                 (pop),
      .clearing            (clearing),
      .rsp_valid           (rsp_valid),
      .rsp_status          (rsp_status),
      .rsp_flow_index      (rsp_flow_index),
      .rsp_flow_start_time (rsp_flow_start_time)
   );

endmodule
`default_nettype wire
